// ===== design/oidtl_pkg.sv =====
// Shared package for the object identifier table block.
// Holds request kind codes, status codes, compare codes, field widths and default sizes; no dependencies.
`timescale 1ns / 1ps

package oidtl_pkg;

  // default table size and arc limit
  localparam int TableEntriesDef = 32;
  localparam int MaxArcsDef      = 16;

  // fixed field widths
  localparam int ArcW    = 32;
  localparam int IndexW  = 5;

  // request kinds
  typedef enum logic [1:0] {
    KIND_REGISTER = 2'd0,
    KIND_EXACT    = 2'd1,
    KIND_NEXT     = 2'd2,
    KIND_CLEAR    = 2'd3
  } kind_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_BAD_LEN   = 2'd3
  } status_e;

  // running result of an arc-by-arc compare
  typedef enum logic [1:0] {
    CMP_EQ = 2'd0,
    CMP_LT = 2'd1,
    CMP_GT = 2'd2
  } cmp_e;

endpackage

// ===== design/oidtl_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module oidtl_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/oidtl_cell.sv =====
// One arc position of the key, candidate and best rings.
// Depends on oidtl_pkg for the arc width.
`timescale 1ns / 1ps

module oidtl_cell (
  input  logic                       clk_i,
  input  logic                       load_i,
  input  logic [oidtl_pkg::ArcW-1:0] load_arc_i,
  input  logic                       key_rot_i,
  input  logic [oidtl_pkg::ArcW-1:0] key_nb_i,
  input  logic                       cand_shift_i,
  input  logic [oidtl_pkg::ArcW-1:0] cand_nb_i,
  input  logic                       best_rot_i,
  input  logic                       best_copy_i,
  input  logic [oidtl_pkg::ArcW-1:0] best_nb_i,
  output logic [oidtl_pkg::ArcW-1:0] key_o,
  output logic [oidtl_pkg::ArcW-1:0] cand_o,
  output logic [oidtl_pkg::ArcW-1:0] best_o
);

  logic [oidtl_pkg::ArcW-1:0] key_q, key_d;
  logic [oidtl_pkg::ArcW-1:0] cand_q, cand_d;
  logic [oidtl_pkg::ArcW-1:0] best_q, best_d;

  // next values: load or rotate key, shift candidate, copy or rotate best
  always_comb begin
    key_d = key_q;
    if (load_i) begin
      key_d = load_arc_i;
    end else if (key_rot_i) begin
      key_d = key_nb_i;
    end
    cand_d = cand_shift_i ? cand_nb_i : cand_q;
    best_d = best_q;
    if (best_copy_i) begin
      best_d = cand_d;
    end else if (best_rot_i) begin
      best_d = best_nb_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    cand_q <= cand_d;
    best_q <= best_d;
  end

  assign key_o  = key_q;
  assign cand_o = cand_q;
  assign best_o = best_q;

endmodule

// ===== design/oid_table_exact_and_next_lookup_top.sv =====
// Top level of the object identifier table: control, rings of arc cells, table RAMs.
// Depends on oidtl_pkg, oidtl_cell and oidtl_ram.
//
//  channel   | ports                                        | marker
//  ----------+----------------------------------------------+----------------------
//  request   | kind_i, arc_i, arc_last_i                    | start_i high, busy_o low
//  result    | status_o, entry_index_o, object_known_o,     | valid_o, one cycle
//            | result_arc_o, result_last_o                  |
//
// Key arcs without arc_last give no result; clear, failed register and empty-table lookups
// answer in the next cycle. Register: result in the next cycle, then busy while S_WRITE
// writes the key into the entry's row of the arc RAM. Lookups scan the whole table
// through the cell ring, one arc a cycle (no scan on an empty table); next then
// emits the best entry, one arc a cycle.
// Reset clears control state only; the table needs no clearing pass.
// The receiver cannot stall; results are strobed for one cycle.
`timescale 1ns / 1ps

module oid_table_exact_and_next_lookup_top #(
  parameter int TABLE_ENTRIES = oidtl_pkg::TableEntriesDef,
  parameter int MAX_ARCS      = oidtl_pkg::MaxArcsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [1:0]                   kind_i,
  input  logic [oidtl_pkg::ArcW-1:0]   arc_i,
  input  logic                         arc_last_i,
  output logic                         valid_o,
  output logic [1:0]                   status_o,
  output logic [oidtl_pkg::IndexW-1:0] entry_index_o,
  output logic                         object_known_o,
  output logic [oidtl_pkg::ArcW-1:0]   result_arc_o,
  output logic                         result_last_o
);

  localparam int IW    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int LD    = (TABLE_ENTRIES > 1) ? TABLE_ENTRIES : 2;
  localparam int CW    = $clog2(TABLE_ENTRIES + 1);
  localparam int Depth = TABLE_ENTRIES * MAX_ARCS;
  localparam int AW    = $clog2(Depth);
  localparam int AFW   = $clog2(Depth + 1);
  localparam int JW    = $clog2(MAX_ARCS);
  localparam int KLW   = $clog2(MAX_ARCS + 2);
  localparam int XW    = oidtl_pkg::IndexW;
  localparam int AR    = oidtl_pkg::ArcW;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WRITE,
    S_SCAN,
    S_EMIT
  } state_e;

  state_e               state_q;
  logic [KLW-1:0]       klen_q;
  logic                 ovf_q;
  logic [KLW-1:0]       keff_q;
  oidtl_pkg::kind_e     op_q;
  logic [CW-1:0]        count_q;
  logic [AFW-1:0]       wbase_q;
  logic [JW-1:0]        wj_q;
  // scan issue side
  logic                 iss_act_q;
  logic [AW-1:0]        iss_addr_q;
  logic [IW-1:0]        iss_i_q;
  logic [JW-1:0]        iss_j_q;
  // scan data side
  logic                 d_valid_q;
  logic [IW-1:0]        d_i_q;
  logic [JW-1:0]        d_j_q;
  logic                 d_end_q;
  oidtl_pkg::cmp_e      dk_q, db_q;
  logic                 pm_q;
  logic                 found_q, known_q, have_q;
  logic [IW-1:0]        found_idx_q, best_idx_q;
  logic [KLW-1:0]       best_len_q;
  logic [KLW-1:0]       ecnt_q;
  // result register
  logic                 valid_q;
  oidtl_pkg::status_e   status_q;
  logic [XW-1:0]        index_q;
  logic                 known_out_q;
  logic [AR-1:0]        arc_out_q;
  logic                 last_out_q;

  // ring wiring
  logic [AR-1:0] key_w  [MAX_ARCS];
  logic [AR-1:0] cand_w [MAX_ARCS];
  logic [AR-1:0] best_w [MAX_ARCS];

  logic acc, key_rot, cand_shift, best_rot, best_copy;

  // RAM ports
  logic            arc_we, len_we;
  logic [AW-1:0]   arc_waddr;
  logic [AR-1:0]   arc_rdata;
  logic [IW-1:0]   len_waddr;
  logic [KLW-1:0]  len_rdata;

  // gather helpers
  logic           kl_inc;
  logic [KLW-1:0] klen_g, keff_g;
  logic           ovf_g;

  // compare helpers
  logic [KLW-1:0]  dj_ext, mink, minb;
  oidtl_pkg::cmp_e dk_n, db_n, cmpk, cmpb;
  logic            pm_n, first, act_k, act_b, greater, better, prefix_ok, entry_end;
  logic            found_n, known_n, have_n;
  logic [IW-1:0]   found_idx_n;

  // index extensions to the 5-bit result field
  logic [IW+XW-1:0] cnt_ext, fidx_ext, bidx_ext;

  assign acc = start_i && (state_q == S_IDLE);

  // key gathering
  always_comb begin
    kl_inc = klen_q < KLW'(MAX_ARCS);
    klen_g = kl_inc ? klen_q + KLW'(1) : klen_q;
    ovf_g  = ovf_q | ~kl_inc;
    keff_g = klen_g + KLW'(ovf_g);
  end

  assign key_rot    = d_valid_q || (state_q == S_WRITE);
  assign cand_shift = d_valid_q;
  assign best_rot   = d_valid_q || (state_q == S_EMIT);

  // row of cells: key and best rotate, candidate fills from the RAM
  for (genvar k = 0; k < MAX_ARCS; k++) begin : g_cell
    localparam int Nb = (k == MAX_ARCS - 1) ? 0 : k + 1;
    logic [AR-1:0] cand_in;
    assign cand_in = (k == MAX_ARCS - 1) ? arc_rdata : cand_w[Nb];
    oidtl_cell u_cell (
      .clk_i        (clk_i),
      .load_i       (acc && (kind_i != oidtl_pkg::KIND_CLEAR) && kl_inc &&
                     (klen_q == KLW'(k))),
      .load_arc_i   (arc_i),
      .key_rot_i    (key_rot),
      .key_nb_i     (key_w[Nb]),
      .cand_shift_i (cand_shift),
      .cand_nb_i    (cand_in),
      .best_rot_i   (best_rot),
      .best_copy_i  (best_copy),
      .best_nb_i    (best_w[Nb]),
      .key_o        (key_w[k]),
      .cand_o       (cand_w[k]),
      .best_o       (best_w[k])
    );
  end

  // table storage
  assign arc_we    = (state_q == S_WRITE);
  assign arc_waddr = AW'(wbase_q + AFW'(wj_q));
  assign len_we    = (state_q == S_WRITE) && (wj_q == '0);
  assign len_waddr = count_q[IW-1:0];

  oidtl_ram #(.Width(AR), .Depth(Depth)) u_arc_ram (
    .clk_i   (clk_i),
    .we_i    (arc_we),
    .waddr_i (arc_waddr),
    .wdata_i (key_w[0]),
    .raddr_i (iss_addr_q),
    .rdata_o (arc_rdata)
  );

  oidtl_ram #(.Width(KLW), .Depth(LD)) u_len_ram (
    .clk_i   (clk_i),
    .we_i    (len_we),
    .waddr_i (len_waddr),
    .wdata_i (keff_q),
    .raddr_i (iss_i_q),
    .rdata_o (len_rdata)
  );

  // per-arc compare of the streamed entry against key and best
  always_comb begin
    first  = (d_j_q == '0);
    dj_ext = KLW'(d_j_q);
    mink   = (len_rdata < keff_q) ? len_rdata : keff_q;
    minb   = (len_rdata < best_len_q) ? len_rdata : best_len_q;
    act_k  = dj_ext < mink;
    act_b  = have_q && (dj_ext < minb);

    dk_n = first ? oidtl_pkg::CMP_EQ : dk_q;
    if (dk_n == oidtl_pkg::CMP_EQ && act_k && arc_rdata != key_w[0]) begin
      dk_n = (arc_rdata < key_w[0]) ? oidtl_pkg::CMP_LT : oidtl_pkg::CMP_GT;
    end
    db_n = first ? oidtl_pkg::CMP_EQ : db_q;
    if (db_n == oidtl_pkg::CMP_EQ && act_b && arc_rdata != best_w[0]) begin
      db_n = (arc_rdata < best_w[0]) ? oidtl_pkg::CMP_LT : oidtl_pkg::CMP_GT;
    end
    pm_n = (first ? 1'b0 : pm_q) ||
           ((dj_ext < len_rdata - KLW'(1)) && (arc_rdata != key_w[0]));

    // a tie on the common arcs falls back to length
    cmpk = dk_n;
    if (dk_n == oidtl_pkg::CMP_EQ) begin
      cmpk = (len_rdata < keff_q) ? oidtl_pkg::CMP_LT :
             (len_rdata > keff_q) ? oidtl_pkg::CMP_GT : oidtl_pkg::CMP_EQ;
    end
    cmpb = db_n;
    if (db_n == oidtl_pkg::CMP_EQ) begin
      cmpb = (len_rdata < best_len_q) ? oidtl_pkg::CMP_LT :
             (len_rdata > best_len_q) ? oidtl_pkg::CMP_GT : oidtl_pkg::CMP_EQ;
    end

    entry_end = d_valid_q && (d_j_q == JW'(MAX_ARCS - 1));
    greater   = (cmpk == oidtl_pkg::CMP_GT);
    better    = !have_q || (cmpb == oidtl_pkg::CMP_LT);
    prefix_ok = (len_rdata - KLW'(1) <= keff_q) && !pm_n;
    best_copy = entry_end && (op_q == oidtl_pkg::KIND_NEXT) && greater && better;

    found_n     = found_q;
    found_idx_n = found_idx_q;
    known_n     = known_q;
    have_n      = have_q;
    if (entry_end) begin
      if (!found_q && cmpk == oidtl_pkg::CMP_EQ) begin
        found_n     = 1'b1;
        found_idx_n = d_i_q;
      end
      known_n = known_q || prefix_ok || (cmpk == oidtl_pkg::CMP_EQ);
      have_n  = have_q || best_copy;
    end
  end

  assign cnt_ext  = {{XW{1'b0}}, count_q[IW-1:0]};
  assign fidx_ext = {{XW{1'b0}}, found_idx_n};
  assign bidx_ext = {{XW{1'b0}}, best_copy ? d_i_q : best_idx_q};

  // control state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      klen_q      <= '0;
      ovf_q       <= 1'b0;
      keff_q      <= '0;
      op_q        <= oidtl_pkg::KIND_REGISTER;
      count_q     <= '0;
      wbase_q     <= '0;
      wj_q        <= '0;
      iss_act_q   <= 1'b0;
      iss_addr_q  <= '0;
      iss_i_q     <= '0;
      iss_j_q     <= '0;
      d_valid_q   <= 1'b0;
      d_i_q       <= '0;
      d_j_q       <= '0;
      d_end_q     <= 1'b0;
      dk_q        <= oidtl_pkg::CMP_EQ;
      db_q        <= oidtl_pkg::CMP_EQ;
      pm_q        <= 1'b0;
      found_q     <= 1'b0;
      known_q     <= 1'b0;
      have_q      <= 1'b0;
      found_idx_q <= '0;
      best_idx_q  <= '0;
      best_len_q  <= '0;
      ecnt_q      <= '0;
      valid_q     <= 1'b0;
      status_q    <= oidtl_pkg::ST_OK;
      index_q     <= '0;
      known_out_q <= 1'b0;
      arc_out_q   <= '0;
      last_out_q  <= 1'b0;
    end else begin
      valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (acc) begin
            // default single result, filled in below
            index_q     <= '0;
            known_out_q <= 1'b0;
            arc_out_q   <= '0;
            last_out_q  <= 1'b1;
            if (kind_i == oidtl_pkg::KIND_CLEAR) begin
              count_q  <= '0;
              wbase_q  <= '0;
              klen_q   <= '0;
              ovf_q    <= 1'b0;
              valid_q  <= 1'b1;
              status_q <= oidtl_pkg::ST_OK;
            end else if (!arc_last_i) begin
              klen_q <= klen_g;
              ovf_q  <= ovf_g;
            end else begin
              klen_q <= '0;
              ovf_q  <= 1'b0;
              keff_q <= keff_g;
              op_q   <= oidtl_pkg::kind_e'(kind_i);
              priority if (kind_i == oidtl_pkg::KIND_REGISTER) begin
                valid_q <= 1'b1;
                if (count_q >= CW'(TABLE_ENTRIES)) begin
                  status_q <= oidtl_pkg::ST_FULL;
                end else if (keff_g < KLW'(2) || keff_g > KLW'(MAX_ARCS)) begin
                  status_q <= oidtl_pkg::ST_BAD_LEN;
                end else begin
                  status_q <= oidtl_pkg::ST_OK;
                  index_q  <= cnt_ext[XW-1:0];
                  wj_q     <= '0;
                  state_q  <= S_WRITE;
                end
              end else if (count_q == '0) begin
                valid_q  <= 1'b1;
                status_q <= oidtl_pkg::ST_NOT_FOUND;
              end else begin
                state_q    <= S_SCAN;
                iss_act_q  <= 1'b1;
                iss_addr_q <= '0;
                iss_i_q    <= '0;
                iss_j_q    <= '0;
                found_q    <= 1'b0;
                known_q    <= 1'b0;
                have_q     <= 1'b0;
              end
            end
          end
        end

        S_WRITE: begin
          // one key arc per cycle into the entry's row
          wj_q <= wj_q + JW'(1);
          if (wj_q == JW'(MAX_ARCS - 1)) begin
            count_q <= count_q + CW'(1);
            wbase_q <= wbase_q + AFW'(MAX_ARCS);
            state_q <= S_IDLE;
          end
        end

        S_SCAN: begin
          // issue addresses, one arc a cycle across all entries
          if (iss_act_q) begin
            iss_addr_q <= iss_addr_q + AW'(1);
            if (iss_j_q == JW'(MAX_ARCS - 1)) begin
              iss_j_q <= '0;
              iss_i_q <= iss_i_q + IW'(1);
              if (CW'(iss_i_q) + CW'(1) == count_q) begin
                iss_act_q <= 1'b0;
              end
            end else begin
              iss_j_q <= iss_j_q + JW'(1);
            end
          end
          d_valid_q <= iss_act_q;
          d_i_q     <= iss_i_q;
          d_j_q     <= iss_j_q;
          d_end_q   <= iss_act_q && (iss_j_q == JW'(MAX_ARCS - 1)) &&
                       (CW'(iss_i_q) + CW'(1) == count_q);
          // compare side
          if (d_valid_q) begin
            dk_q        <= dk_n;
            db_q        <= db_n;
            pm_q        <= pm_n;
            found_q     <= found_n;
            found_idx_q <= found_idx_n;
            known_q     <= known_n;
            have_q      <= have_n;
            if (best_copy) begin
              best_idx_q <= d_i_q;
              best_len_q <= len_rdata;
            end
          end
          if (d_valid_q && d_end_q) begin
            d_valid_q <= 1'b0;
            d_end_q   <= 1'b0;
            if (op_q == oidtl_pkg::KIND_EXACT) begin
              valid_q     <= 1'b1;
              status_q    <= found_n ? oidtl_pkg::ST_OK : oidtl_pkg::ST_NOT_FOUND;
              index_q     <= found_n ? fidx_ext[XW-1:0] : '0;
              known_out_q <= known_n;
              state_q     <= S_IDLE;
            end else if (!have_n) begin
              valid_q  <= 1'b1;
              status_q <= oidtl_pkg::ST_NOT_FOUND;
              state_q  <= S_IDLE;
            end else begin
              ecnt_q  <= '0;
              state_q <= S_EMIT;
            end
          end
        end

        S_EMIT: begin
          // one arc of the best entry per cycle
          valid_q     <= 1'b1;
          status_q    <= oidtl_pkg::ST_OK;
          index_q     <= bidx_ext[XW-1:0];
          known_out_q <= 1'b0;
          arc_out_q   <= best_w[0];
          last_out_q  <= (ecnt_q + KLW'(1) == best_len_q);
          ecnt_q      <= ecnt_q + KLW'(1);
          if (ecnt_q + KLW'(1) == best_len_q) begin
            state_q <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o         = (state_q != S_IDLE);
  assign valid_o        = valid_q;
  assign status_o       = status_q;
  assign entry_index_o  = index_q;
  assign object_known_o = known_out_q;
  assign result_arc_o   = arc_out_q;
  assign result_last_o  = last_out_q;

endmodule

// ===== design/oidtl_checker.sv =====
// Port-level checker for the object identifier table, bound to the top level.
// Depends on oidtl_pkg and oid_table_exact_and_next_lookup_top.
`timescale 1ns / 1ps

module oidtl_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start_i,
  input logic                         busy_o,
  input logic [1:0]                   kind_i,
  input logic [oidtl_pkg::ArcW-1:0]   arc_i,
  input logic                         arc_last_i,
  input logic                         valid_o,
  input logic [1:0]                   status_o,
  input logic [oidtl_pkg::IndexW-1:0] entry_index_o,
  input logic                         object_known_o,
  input logic [oidtl_pkg::ArcW-1:0]   result_arc_o,
  input logic                         result_last_o
);

  // arcs of a next result come back to back
  a_emit_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !result_last_o |=> valid_o)
    else $error("next result arcs not contiguous");

  // a clear answers in the next cycle with a single done result
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && kind_i == oidtl_pkg::KIND_CLEAR |=>
      valid_o && result_last_o && status_o == oidtl_pkg::ST_OK)
    else $error("clear result missing");

  // failures are single results with zero payload
  a_fail_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && status_o != oidtl_pkg::ST_OK |->
      result_last_o && entry_index_o == '0 && result_arc_o == '0)
    else $error("failure result malformed");

  // register always answers in the next cycle
  a_reg_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && kind_i == oidtl_pkg::KIND_REGISTER && arc_last_i |=> valid_o)
    else $error("register result missing");

  // object_known only on exact lookups, which carry no arc
  a_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && object_known_o |-> result_arc_o == '0 && result_last_o)
    else $error("object_known on wrong result");

endmodule

bind oid_table_exact_and_next_lookup_top oidtl_checker u_oidtl_checker (.*);

// ===== test/oid_table_exact_and_next_lookup_top_tb.sv =====
// Testbench for the object identifier table: register, exact lookup, next lookup, clear.
// Depends on oidtl_pkg and oid_table_exact_and_next_lookup_top.
`timescale 1ns / 1ps

module oid_table_exact_and_next_lookup_top_tb;

  localparam int NENT = oidtl_pkg::TableEntriesDef;
  localparam int NARC = oidtl_pkg::MaxArcsDef;
  localparam int WDOG = 20000;

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  index;
    logic        known;
    logic [31:0] arc;
    logic        last;
  } oid_result_t;

  typedef struct {
    oidtl_pkg::kind_e kind;
    logic [31:0]      arc;
    logic             last;
    logic             typed;
    oid_result_t      res;
  } dir_row_t;

  logic        clk_i, rst_ni, start_i, arc_last_i;
  logic [1:0]  kind_i;
  logic [31:0] arc_i;
  logic        busy_o, valid_o, object_known_o, result_last_o;
  logic [1:0]  status_o;
  logic [4:0]  entry_index_o;
  logic [31:0] result_arc_o;

  oid_table_exact_and_next_lookup_top DUT (.*);

  // predictor state
  logic [31:0] key_q [NARC];
  int          key_len, entry_cnt;
  bit          key_ovf;
  logic [31:0] tbl_arcs [NENT][NARC];
  int          tbl_len [NENT];

  oid_result_t pending_q [$];
  int          mismatches, idle_cnt;
  int          send_idle;
  dir_row_t    dir [$];

  // lexicographic compare of entry e against the gathered key (klen)
  function automatic int cmp_entry_key(int e, int klen, logic [31:0] k [NARC]);
    int n;
    n = (tbl_len[e] < klen) ? tbl_len[e] : klen;
    for (int i = 0; i < n; i++) begin
      if (tbl_arcs[e][i] < k[i]) return -1;
      if (tbl_arcs[e][i] > k[i]) return 1;
    end
    return (tbl_len[e] < klen) ? -1 : (tbl_len[e] > klen) ? 1 : 0;
  endfunction

  function automatic int cmp_entries(int a, int b);
    int n;
    n = (tbl_len[a] < tbl_len[b]) ? tbl_len[a] : tbl_len[b];
    for (int i = 0; i < n; i++) begin
      if (tbl_arcs[a][i] < tbl_arcs[b][i]) return -1;
      if (tbl_arcs[a][i] > tbl_arcs[b][i]) return 1;
    end
    return (tbl_len[a] < tbl_len[b]) ? -1 : (tbl_len[a] > tbl_len[b]) ? 1 : 0;
  endfunction

  function automatic oid_result_t mk(logic [1:0] s, int idx, bit kn, logic [31:0] a, bit l);
    oid_result_t r;
    r.status = s; r.index = idx[4:0]; r.known = kn; r.arc = a; r.last = l;
    return r;
  endfunction

  // work out the results of one accepted request
  task automatic predict_oid(oidtl_pkg::kind_e kind, logic [31:0] arc, logic last);
    int  klen, best, objn;
    bit  found, kn, have;
    int  idx;
    found = 0; kn = 0; have = 0; idx = 0; best = 0;
    if (kind == oidtl_pkg::KIND_CLEAR) begin
      entry_cnt = 0; key_len = 0; key_ovf = 0;
      pending_q.push_back(mk(oidtl_pkg::ST_OK, 0, 0, 0, 1));
      return;
    end
    if (key_len < NARC) begin
      key_q[key_len] = arc;
      key_len++;
    end else key_ovf = 1;
    if (!last) return;
    klen = key_len + (key_ovf ? 1 : 0);
    key_len = 0; key_ovf = 0;
    case (kind)
      oidtl_pkg::KIND_REGISTER: begin
        if (entry_cnt >= NENT) pending_q.push_back(mk(oidtl_pkg::ST_FULL, 0, 0, 0, 1));
        else if (klen < 2 || klen > NARC)
          pending_q.push_back(mk(oidtl_pkg::ST_BAD_LEN, 0, 0, 0, 1));
        else begin
          for (int i = 0; i < klen; i++) tbl_arcs[entry_cnt][i] = key_q[i];
          tbl_len[entry_cnt] = klen;
          pending_q.push_back(mk(oidtl_pkg::ST_OK, entry_cnt, 0, 0, 1));
          entry_cnt++;
        end
      end
      oidtl_pkg::KIND_EXACT: begin
        for (int i = 0; i < entry_cnt; i++)
          if (!found && cmp_entry_key(i, klen, key_q) == 0) begin
            found = 1; idx = i;
          end
        for (int i = 0; i < entry_cnt; i++) begin
          objn = tbl_len[i] - 1;
          if (objn <= klen) begin
            bit eq;
            eq = 1;
            for (int j = 0; j < objn; j++) if (tbl_arcs[i][j] != key_q[j]) eq = 0;
            if (eq) kn = 1;
          end
        end
        if (found) kn = 1;
        pending_q.push_back(mk(found ? oidtl_pkg::ST_OK : oidtl_pkg::ST_NOT_FOUND,
                               idx, kn, 0, 1));
      end
      default: begin
        for (int i = 0; i < entry_cnt; i++)
          if (cmp_entry_key(i, klen, key_q) > 0)
            if (!have || cmp_entries(i, best) < 0) begin
              have = 1; best = i;
            end
        if (!have) pending_q.push_back(mk(oidtl_pkg::ST_NOT_FOUND, 0, 0, 0, 1));
        else for (int k = 0; k < tbl_len[best]; k++)
          pending_q.push_back(mk(oidtl_pkg::ST_OK, best, 0, tbl_arcs[best][k],
                                 k + 1 == tbl_len[best]));
      end
    endcase
  endtask

  // clock
  initial begin
    clk_i = 0;
    forever #6 clk_i = ~clk_i;
  end

  // result checking and watchdog
  always @(posedge clk_i) begin
    oid_result_t got, want;
    if (rst_ni) begin
      if ((start_i && !busy_o) || valid_o) idle_cnt <= 0;
      else idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= WDOG) begin
        $display("TEST FAILED");
        $finish;
      end
      if (valid_o) begin
        got = mk(status_o, entry_index_o, object_known_o, result_arc_o, result_last_o);
        if (pending_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", got);
        end else begin
          want = pending_q.pop_front();
          if (got != want) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch exp %p got %p", want, got);
          end
        end
      end
    end
  end

  // one request: hold until accepted; start stays high into the next request
  // unless the phase inserts idle cycles
  task automatic send_req(oidtl_pkg::kind_e kind, logic [31:0] arc, logic last);
    if ($urandom_range(99) < send_idle) begin
      start_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle);
    end
    start_i <= 1'b1; kind_i <= kind; arc_i <= arc; arc_last_i <= last;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    predict_oid(kind, arc, last);
  endtask

  task automatic send_key(oidtl_pkg::kind_e kind, int n, int pick);
    logic [31:0] a;
    for (int i = 0; i < n; i++) begin
      // pick from existing entry prefix to reach matches and near-misses
      if (pick >= 0 && i < tbl_len[pick] && $urandom_range(9) < 8) a = tbl_arcs[pick][i];
      else case ($urandom_range(3))
        0: a = $urandom;
        1: a = 32'hFFFF_FFFF - $urandom_range(1);
        default: a = $urandom_range(3);
      endcase
      send_req(($urandom_range(9) == 0) ? oidtl_pkg::kind_e'($urandom_range(2)) : kind,
               a, 1'b0);
    end
  endtask

  task automatic add_dir(oidtl_pkg::kind_e k, logic [31:0] a, logic l, logic t,
                         oid_result_t r);
    dir_row_t d;
    d.kind = k; d.arc = a; d.last = l; d.typed = t; d.res = r;
    dir.push_back(d);
  endtask

  initial begin
    int n, pick;
    oidtl_pkg::kind_e k;
    oid_result_t none;
    none = '0;
    start_i = 0; kind_i = oidtl_pkg::KIND_CLEAR; arc_i = 0; arc_last_i = 0;
    mismatches = 0; idle_cnt = 0; send_idle = 0;
    key_len = 0; key_ovf = 0; entry_cnt = 0;
    rst_ni = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed table
    add_dir(oidtl_pkg::KIND_NEXT, 32'd5, 1, 1, mk(oidtl_pkg::ST_NOT_FOUND, 0, 0, 0, 1));
    add_dir(oidtl_pkg::KIND_EXACT, 32'd5, 1, 1, mk(oidtl_pkg::ST_NOT_FOUND, 0, 0, 0, 1));
    add_dir(oidtl_pkg::KIND_REGISTER, 32'd1, 1, 1, mk(oidtl_pkg::ST_BAD_LEN, 0, 0, 0, 1));
    add_dir(oidtl_pkg::KIND_REGISTER, 32'hFFFF_FFFF, 0, 0, none);
    add_dir(oidtl_pkg::KIND_REGISTER, 32'd0, 1, 1, mk(oidtl_pkg::ST_OK, 0, 0, 0, 1));
    add_dir(oidtl_pkg::KIND_REGISTER, 32'd1, 0, 0, none);
    add_dir(oidtl_pkg::KIND_EXACT, 32'd3, 0, 0, none);
    add_dir(oidtl_pkg::KIND_REGISTER, 32'd2, 1, 1, mk(oidtl_pkg::ST_OK, 1, 0, 0, 1));
    add_dir(oidtl_pkg::KIND_EXACT, 32'hFFFF_FFFF, 0, 0, none);
    add_dir(oidtl_pkg::KIND_EXACT, 32'd0, 1, 0, none);
    add_dir(oidtl_pkg::KIND_EXACT, 32'hFFFF_FFFF, 0, 0, none);
    add_dir(oidtl_pkg::KIND_EXACT, 32'd7, 0, 0, none);
    add_dir(oidtl_pkg::KIND_EXACT, 32'd9, 1, 0, none);
    add_dir(oidtl_pkg::KIND_NEXT, 32'd0, 1, 0, none);
    add_dir(oidtl_pkg::KIND_REGISTER, 32'd4, 0, 0, none);
    add_dir(oidtl_pkg::KIND_CLEAR, 32'hFFFF_FFFF, 0, 1, mk(oidtl_pkg::ST_OK, 0, 0, 0, 1));
    add_dir(oidtl_pkg::KIND_NEXT, 32'd0, 1, 1, mk(oidtl_pkg::ST_NOT_FOUND, 0, 0, 0, 1));
    foreach (dir[i]) begin
      send_req(dir[i].kind, dir[i].arc, dir[i].last);
      if (dir[i].typed && pending_q.size() > 0 && pending_q[$] != dir[i].res) begin
        mismatches++;
        if (mismatches <= 10)
          $display("table row %0d exp %p got %p", i, dir[i].res, pending_q[$]);
      end
    end
    // overlong key, register and lookups of it
    for (int r = 0; r < 3; r++)
      for (int i = 0; i <= NARC; i++)
        send_req(oidtl_pkg::kind_e'(r), 32'hFFFF_FFFF, i == NARC);
    // fill the table to full, the first entry at max length
    for (int e = 0; e <= NENT; e++)
      for (int i = 0; i < ((e == 0) ? NARC : 2); i++)
        send_req(oidtl_pkg::KIND_REGISTER, e[31:0] + i,
                 i == ((e == 0) ? NARC : 2) - 1);
    send_req(oidtl_pkg::KIND_REGISTER, 0, 1);
    for (int i = 0; i < 3; i++) send_req(oidtl_pkg::KIND_NEXT, 32'd8, i == 2);

    // random part in idle phases
    for (int ph = 0; ph < 4; ph++) begin
      send_idle = (ph == 1) ? 56 : (ph == 3) ? 30 : 0;
      if ($urandom_range(1))
        send_req(oidtl_pkg::KIND_CLEAR, $urandom, 1'($urandom_range(1)));
      for (int it = 0; it < 4; it++) begin
        n = ($urandom_range(9) == 0) ? $urandom_range(NARC + 2, 1) : $urandom_range(5, 1);
        pick = (entry_cnt > 0) ? $urandom_range(entry_cnt - 1) : -1;
        case ($urandom_range(9))
          0, 1, 2, 3: k = oidtl_pkg::KIND_REGISTER;
          4, 5, 6: k = oidtl_pkg::KIND_EXACT;
          default: k = oidtl_pkg::KIND_NEXT;
        endcase
        if ($urandom_range(30) == 0) k = oidtl_pkg::KIND_CLEAR;
        if (k == oidtl_pkg::KIND_CLEAR)
          send_req(oidtl_pkg::KIND_CLEAR, $urandom, 1'($urandom_range(1)));
        else begin
          send_key(k, n - 1, pick);
          send_req(k, (pick >= 0 && n - 1 < tbl_len[pick] && $urandom_range(1))
                       ? tbl_arcs[pick][n - 1] : $urandom_range(4), 1'b1);
        end
      end
    end
    start_i <= 1'b0;

    // drain
    while (pending_q.size() > 0) @(posedge clk_i);
    repeat (NENT * NARC + 40) @(posedge clk_i);
    if (mismatches == 0 && pending_q.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
